// ===== hw/rtl/adcs_pkg.sv =====
`default_nettype none
package adcs_pkg;

  localparam int OutDepth = 4096;
  localparam int AddrW = 12;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;
  localparam logic [31:0] LogGain = 32'd3232284966;

  typedef enum logic [1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    METH_LIN  = 2'd0,
    METH_LOG  = 2'd1,
    METH_SQR  = 2'd2,
    METH_ROOT = 2'd3
  } method_t;

  typedef enum logic [2:0] {
    REG_DIM_SIZES      = 3'd0,
    REG_NUM_DIMS       = 3'd1,
    REG_KEEP_ORDER     = 3'd2,
    REG_KEEP_COUNT     = 3'd3,
    REG_METHOD         = 3'd4,
    REG_REMOVE_MISSING = 3'd5,
    REG_SCALE          = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [63:0]        dim_sizes;
    logic [2:0]         num_dims;
    logic [7:0]         keep_order;
    logic [2:0]         keep_count;
    logic [1:0]         method;
    logic               remove_missing;
    logic signed [31:0] scale;
  } cfg_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] sample;
    logic               missing;
    logic               over;
    logic [AddrW-1:0]   addr;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ADDR,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_DECIDE,
    B_NORM,
    B_LOG,
    B_LOGMUL,
    B_LOGRND,
    B_ROOT,
    B_ROOTEND,
    B_MUL,
    B_RND,
    B_ADD,
    B_WRITE,
    B_OUT
  } back_state_t;

  function automatic logic [15:0] eff_size(input logic [63:0] ds, input logic [1:0] d);
    logic [15:0] s;
    s = ds[{d, 4'b0000} +: 16];
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

  function automatic logic [2:0] dims_used(input logic [2:0] n);
    logic [2:0] r;
    r = n;
    if (n == 3'd0) r = 3'd1;
    if (n > 3'd4) r = 3'd4;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/adcs_item_if.sv =====
`default_nettype none
interface adcs_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] sample;
  logic               sample_missing;
  logic [11:0]        read_index;
  modport source(output valid, func, sample, sample_missing, read_index, input ready);
  modport sink(input valid, func, sample, sample_missing, read_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/adcs_sum_if.sv =====
`default_nettype none
interface adcs_sum_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] sum_value;
  logic               sum_missing;
  modport source(output valid, sum_value, sum_missing, input ready);
  modport sink(input valid, sum_value, sum_missing, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/array_dim_collapse_sum_unit.sv =====
// Marginal sum unit: folds a column-major array of up to four dimensions onto
// the kept dimensions, accumulating transformed and scaled elements per entry.
// The item channel carries one command per transaction: accumulate an element,
// read one accumulator entry, or restart. Only a read returns a transaction on
// the sum channel, carrying the saturated Q47.16 sum and its missing mark.
// The front end takes one command at a time: it computes an element's entry
// address and steps the coordinate counters, passes a read or restart on and
// drops an unused command. A four-entry queue decouples it from the back end,
// which works on one command at a time against the 4096-entry accumulator
// memory. A linear or square element passes the multiply, round, add and
// write states; a square root first runs its digit loop, a log its normalize
// loop plus 24 squaring steps. A read is loaded in the decide state and then
// shown on the sum channel. After reset and after every restart the back end
// clears all 4096 memory entries; commands still queue meanwhile. When the
// sum receiver stalls, the result is held, the queue fills, the item channel
// stalls. Registers must be written while the unit is idle; nothing checks.
`default_nettype none
module array_dim_collapse_sum_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  adcs_item_if.sink        item,
  adcs_sum_if.source       sum,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data
);

  adcs_pkg::cfg_t cfg;
  adcs_pkg::job_t front_job;
  adcs_pkg::job_t head;
  logic q_push;
  logic q_full;
  logic q_empty;
  logic pop;
  logic clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_sizes <= 64'h0001_0001_0001_0001;
      cfg.num_dims <= 3'd1;
      cfg.keep_order <= 8'd0;
      cfg.keep_count <= 3'd1;
      cfg.method <= 2'd0;
      cfg.remove_missing <= 1'b0;
      cfg.scale <= 32'sd65536;
    end else if (wr_en) begin
      case (adcs_pkg::reg_index_t'(wr_index))
        adcs_pkg::REG_DIM_SIZES: cfg.dim_sizes <= wr_data;
        adcs_pkg::REG_NUM_DIMS: cfg.num_dims <= wr_data[2:0];
        adcs_pkg::REG_KEEP_ORDER: cfg.keep_order <= wr_data[7:0];
        adcs_pkg::REG_KEEP_COUNT: cfg.keep_count <= wr_data[2:0];
        adcs_pkg::REG_METHOD: cfg.method <= wr_data[1:0];
        adcs_pkg::REG_REMOVE_MISSING: cfg.remove_missing <= wr_data[0];
        adcs_pkg::REG_SCALE: cfg.scale <= wr_data[31:0];
        default: begin
        end
      endcase
    end
  end

  adcs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .full (q_full),
    .job  (front_job),
    .push (q_push)
  );

  adcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .in_job (front_job),
    .push   (q_push),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  adcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .sum      (sum),
    .clearing (clearing)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_empty))
    else $error("Queue read while empty.");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !sum.valid)
    else $error("Result presented during the clearing pass.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.func != adcs_pkg::FUNC_NONE)) |=> !item.ready)
    else $error("Front end accepted two transactions back to back.");

endmodule
`default_nettype wire

// ===== hw/rtl/adcs_front.sv =====
`default_nettype none
module adcs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adcs_pkg::cfg_t     cfg,
  adcs_item_if.sink               item,
  input  wire logic               full,
  output adcs_pkg::job_t          job,
  output logic                    push
);

  adcs_pkg::front_state_t state, state_next;
  logic [15:0] coord [4];
  logic [15:0] coord_next [4];
  logic [12:0] fct;
  logic [1:0]  step;
  logic [2:0]  nd;
  logic [2:0]  kc;
  logic [1:0]  k;
  logic        active;
  logic [15:0] size_k;
  logic [28:0] term;
  logic [29:0] sum;
  logic [28:0] fprod;
  logic        carry;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) state <= adcs_pkg::F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    push = 1'b0;
    case (state)
      adcs_pkg::F_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (adcs_pkg::func_t'(item.func))
            adcs_pkg::FUNC_ACC: state_next = adcs_pkg::F_ADDR;
            adcs_pkg::FUNC_READ, adcs_pkg::FUNC_CLEAR: state_next = adcs_pkg::F_PUSH;
            default: state_next = adcs_pkg::F_IDLE;
          endcase
        end
      end
      adcs_pkg::F_ADDR: begin
        if (step == 2'd3) state_next = adcs_pkg::F_PUSH;
      end
      adcs_pkg::F_PUSH: begin
        push = !full;
        if (!full) state_next = adcs_pkg::F_IDLE;
      end
      default: state_next = adcs_pkg::F_IDLE;
    endcase
  end

  assign accept = item.valid && item.ready;
  assign nd = adcs_pkg::dims_used(cfg.num_dims);
  assign kc = (cfg.keep_count > 3'd4) ? 3'd4 : cfg.keep_count;
  assign k = cfg.keep_order[{step, 1'b0} +: 2];
  assign active = ({1'b0, step} < kc) && ({1'b0, k} < nd);
  assign size_k = adcs_pkg::eff_size(cfg.dim_sizes, k);
  assign term = fct * coord[k];
  assign sum = {18'd0, job.addr} + {1'b0, term};
  assign fprod = fct * size_k;

  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < 4; d++) begin
      coord_next[d] = coord[d];
      if (carry && (3'(d) < nd)) begin
        if (({1'b0, coord[d]} + 17'd1) >= {1'b0, adcs_pkg::eff_size(cfg.dim_sizes, 2'(d))}) begin
          coord_next[d] = 16'd0;
        end else begin
          coord_next[d] = coord[d] + 16'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < 4; d++) coord[d] <= 16'd0;
    end else if (push) begin
      if (job.func == adcs_pkg::FUNC_ACC) begin
        for (int d = 0; d < 4; d++) coord[d] <= coord_next[d];
      end else if (job.func == adcs_pkg::FUNC_CLEAR) begin
        for (int d = 0; d < 4; d++) coord[d] <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.func <= adcs_pkg::func_t'(item.func);
      job.sample <= item.sample;
      job.missing <= item.sample_missing;
      job.over <= 1'b0;
      job.addr <= (adcs_pkg::func_t'(item.func) == adcs_pkg::FUNC_READ) ? item.read_index
                                                                      : '0;
      fct <= 13'd1;
      step <= 2'd0;
    end else if (state == adcs_pkg::F_ADDR) begin
      step <= step + 2'd1;
      if (active && !job.over) begin
        if (|sum[29:12]) job.over <= 1'b1;
        else job.addr <= sum[11:0];
        fct <= (|fprod[28:12]) ? 13'd4096 : fprod[12:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/adcs_queue.sv =====
`default_nettype none
module adcs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire adcs_pkg::job_t in_job,
  input  wire logic           push,
  input  wire logic           pop,
  output adcs_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  adcs_pkg::job_t entries [adcs_pkg::QueueDepth];
  logic [adcs_pkg::QueuePtrW-1:0] wr_ptr;
  logic [adcs_pkg::QueuePtrW-1:0] rd_ptr;
  logic [adcs_pkg::QueuePtrW:0]   count;

  assign full = (count == (adcs_pkg::QueuePtrW+1)'(adcs_pkg::QueueDepth));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_job;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/adcs_back.sv =====
`default_nettype none
module adcs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire adcs_pkg::cfg_t cfg,
  input  wire adcs_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  adcs_sum_if.source          sum,
  output logic                clearing
);

  localparam logic signed [63:0] SatMax = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SatMin = {1'b1, {63{1'b0}}};

  adcs_pkg::back_state_t state, state_next;
  logic [64:0] mem [adcs_pkg::OutDepth];
  logic [64:0] rdata;
  logic        mem_we;
  logic [adcs_pkg::AddrW-1:0] mem_addr;
  logic [64:0] mem_wdata;
  logic [adcs_pkg::AddrW-1:0] clr_addr;

  adcs_pkg::job_t job;
  logic signed [63:0] acc;
  logic        mark;
  logic signed [63:0] t;
  logic [31:0] m;
  logic [4:0]  p;
  logic [28:0] l;
  logic [4:0]  cnt;
  logic [47:0] rn;
  logic [47:0] rr;
  logic [47:0] rbit;
  logic [60:0] lprod;
  logic        lneg;
  logic [63:0] plo;
  logic [47:0] phi;
  logic        mneg;
  logic signed [63:0] gain;
  logic signed [63:0] out_value;
  logic        out_missing;

  logic [31:0] usample;
  logic [63:0] sq_full;
  logic [63:0] msq;
  logic [31:0] msq_s;
  logic signed [29:0] lr;
  logic [28:0] lmag;
  logic [22:0] lval;
  logic [47:0] ua;
  logic [31:0] ub;
  logic [63:0] mag;
  logic [47:0] rsum;
  logic signed [64:0] add_sum;

  always_ff @(posedge clk) begin
    if (rst) state <= adcs_pkg::B_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    case (state)
      adcs_pkg::B_CLEAR: begin
        if (clr_addr == '1) state_next = adcs_pkg::B_IDLE;
      end
      adcs_pkg::B_IDLE: begin
        pop = !empty;
        if (!empty) state_next = adcs_pkg::B_DECIDE;
      end
      adcs_pkg::B_DECIDE: begin
        case (job.func)
          adcs_pkg::FUNC_READ: state_next = adcs_pkg::B_OUT;
          adcs_pkg::FUNC_CLEAR: state_next = adcs_pkg::B_CLEAR;
          adcs_pkg::FUNC_ACC: begin
            state_next = adcs_pkg::B_IDLE;
            if (job.missing) begin
              if (!cfg.remove_missing && !job.over) state_next = adcs_pkg::B_WRITE;
            end else if (!job.over && !rdata[64]) begin
              case (adcs_pkg::method_t'(cfg.method))
                adcs_pkg::METH_LIN, adcs_pkg::METH_SQR: state_next = adcs_pkg::B_MUL;
                adcs_pkg::METH_LOG: state_next = (job.sample <= 0) ? adcs_pkg::B_WRITE
                                                                   : adcs_pkg::B_NORM;
                default: state_next = (job.sample < 0) ? adcs_pkg::B_WRITE
                                                       : adcs_pkg::B_ROOT;
              endcase
            end
          end
          default: state_next = adcs_pkg::B_IDLE;
        endcase
      end
      adcs_pkg::B_NORM: if (m[30]) state_next = adcs_pkg::B_LOG;
      adcs_pkg::B_LOG: if (cnt == 5'd23) state_next = adcs_pkg::B_LOGMUL;
      adcs_pkg::B_LOGMUL: state_next = adcs_pkg::B_LOGRND;
      adcs_pkg::B_LOGRND: state_next = adcs_pkg::B_MUL;
      adcs_pkg::B_ROOT: if (cnt == 5'd23) state_next = adcs_pkg::B_ROOTEND;
      adcs_pkg::B_ROOTEND: state_next = adcs_pkg::B_MUL;
      adcs_pkg::B_MUL: state_next = adcs_pkg::B_RND;
      adcs_pkg::B_RND: state_next = adcs_pkg::B_ADD;
      adcs_pkg::B_ADD: state_next = adcs_pkg::B_WRITE;
      adcs_pkg::B_WRITE: state_next = adcs_pkg::B_IDLE;
      adcs_pkg::B_OUT: if (sum.ready) state_next = adcs_pkg::B_IDLE;
      default: state_next = adcs_pkg::B_IDLE;
    endcase
  end

  assign clearing = (state == adcs_pkg::B_CLEAR);
  assign sum.valid = (state == adcs_pkg::B_OUT);
  assign sum.sum_value = out_value;
  assign sum.sum_missing = out_missing;

  assign mem_we = (state == adcs_pkg::B_CLEAR) || (state == adcs_pkg::B_WRITE);
  assign mem_addr = (state == adcs_pkg::B_CLEAR) ? clr_addr : job.addr;
  assign mem_wdata = (state == adcs_pkg::B_CLEAR) ? 65'd0 : {mark, acc};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (pop) rdata <= mem[head.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (state == adcs_pkg::B_CLEAR) clr_addr <= clr_addr + 1'b1;
  end

  assign usample = job.sample[31] ? 32'(-job.sample) : job.sample;
  assign sq_full = usample * usample;
  assign msq = m * m;
  assign msq_s = msq[61:30];
  assign lr = $signed({1'b0, l}) - 30'sd268435456;
  assign lmag = lr[29] ? 29'(-lr) : lr[28:0];
  assign lval = 23'((lprod + 61'(64'h0000_0020_0000_0000)) >> 38);
  assign ua = t[63] ? 48'(-t) : t[47:0];
  assign ub = cfg.scale[31] ? 32'(-cfg.scale) : cfg.scale;
  assign mag = {phi, 16'd0} + ((plo + 64'h8000) >> 16);
  assign rsum = rr + rbit;
  assign add_sum = {acc[63], acc} + {gain[63], gain};

  always_ff @(posedge clk) begin
    case (state)
      adcs_pkg::B_IDLE: begin
        if (pop) job <= head;
      end
      adcs_pkg::B_DECIDE: begin
        acc <= rdata[63:0];
        mark <= rdata[64];
        out_value <= rdata[63:0];
        out_missing <= rdata[64];
        if (job.missing) begin
          mark <= 1'b1;
        end else begin
          case (adcs_pkg::method_t'(cfg.method))
            adcs_pkg::METH_LIN: t <= 64'(job.sample);
            adcs_pkg::METH_SQR: t <= {16'd0, 48'((sq_full + 64'h8000) >> 16)};
            adcs_pkg::METH_LOG: begin
              if (job.sample <= 0) mark <= 1'b1;
              m <= {1'b0, job.sample[30:0]};
              p <= 5'd30;
            end
            default: begin
              if (job.sample < 0) mark <= 1'b1;
              rn <= {job.sample[31:0], 16'd0};
              rr <= '0;
              rbit <= 48'd1 << 46;
              cnt <= '0;
            end
          endcase
        end
      end
      adcs_pkg::B_NORM: begin
        if (m[30]) begin
          l <= {p, 24'd0};
          cnt <= '0;
        end else begin
          m <= m << 1;
          p <= p - 5'd1;
        end
      end
      adcs_pkg::B_LOG: begin
        cnt <= cnt + 5'd1;
        if (msq_s[31]) begin
          m <= msq_s >> 1;
          l[5'd23 - cnt] <= 1'b1;
        end else begin
          m <= msq_s;
        end
      end
      adcs_pkg::B_LOGMUL: begin
        lneg <= lr[29];
        lprod <= lmag * adcs_pkg::LogGain;
      end
      adcs_pkg::B_LOGRND: begin
        t <= lneg ? -64'(lval) : 64'(lval);
      end
      adcs_pkg::B_ROOT: begin
        cnt <= cnt + 5'd1;
        if (rn >= rsum) begin
          rn <= rn - rsum;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
      end
      adcs_pkg::B_ROOTEND: begin
        t <= (rn > rr) ? 64'(rr + 48'd1) : 64'(rr);
      end
      adcs_pkg::B_MUL: begin
        plo <= ua[31:0] * ub;
        phi <= ua[47:32] * ub;
        mneg <= t[63] != cfg.scale[31];
      end
      adcs_pkg::B_RND: begin
        if (mag[63]) gain <= mneg ? SatMin : SatMax;
        else gain <= mneg ? -$signed(mag) : $signed(mag);
      end
      adcs_pkg::B_ADD: begin
        if (add_sum[64] != add_sum[63]) acc <= add_sum[64] ? SatMin : SatMax;
        else acc <= add_sum[63:0];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import adcs_pkg::*;

  typedef struct {
    longint value;
    bit     missing;
  } sum_t;

  class sum_scoreboard;
    cfg_t     regs;
    bit [15:0] coord[4];
    longint   acc[OutDepth];
    bit       mark[OutDepth];
    sum_t     expected_sums[$];
    int       errors;

    function new();
      regs.dim_sizes = 64'h0001_0001_0001_0001;
      regs.num_dims = 3'd1;
      regs.keep_order = 8'd0;
      regs.keep_count = 3'd1;
      regs.method = METH_LIN;
      regs.remove_missing = 1'b0;
      regs.scale = 32'sd65536;
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (coord[i]) coord[i] = '0;
      foreach (acc[i]) begin
        acc[i] = 0;
        mark[i] = 1'b0;
      end
    endfunction

    function void write_reg(reg_index_t idx, logic [63:0] v);
      case (idx)
        REG_DIM_SIZES:      regs.dim_sizes = v;
        REG_NUM_DIMS:       regs.num_dims = v[2:0];
        REG_KEEP_ORDER:     regs.keep_order = v[7:0];
        REG_KEEP_COUNT:     regs.keep_count = v[2:0];
        REG_METHOD:         regs.method = v[1:0];
        REG_REMOVE_MISSING: regs.remove_missing = v[0];
        REG_SCALE:          regs.scale = v[31:0];
        default: ;
      endcase
    endfunction

    function longint unsigned size_of(int d);
      logic [15:0] s;
      s = regs.dim_sizes[16*d +: 16];
      return (s == 16'd0) ? 64'd1 : 64'(s);
    endfunction

    function int dims_in_use();
      int n;
      n = regs.num_dims;
      if (n == 0) n = 1;
      if (n > 4) n = 4;
      return n;
    endfunction

    function longint from_mag(longint unsigned mag, bit neg);
      if (!neg) return (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
      if (mag >= 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return -longint'(mag);
    endfunction

    function longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return s[63:0];
    endfunction

    function longint gain_product(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, plo, phi, mag;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      plo = (ua & 64'hFFFF_FFFF) * ub;
      phi = (ua >> 32) * ub;
      mag = (phi << 16) + ((plo + 64'h8000) >> 16);
      return from_mag(mag, neg);
    endfunction

    function longint unsigned root_rounded(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return (n > r) ? r + 1 : r;
    endfunction

    function longint decibels(longint unsigned x);
      int p;
      longint unsigned m, l, mag;
      longint lr;
      bit neg;
      p = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = x << (30 - p);
      l = 64'(p) << 24;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          m >>= 1;
          l |= 64'd1 << (23 - i);
        end
      end
      lr = longint'(l) - (64'sd16 <<< 24);
      neg = lr < 0;
      mag = neg ? -lr : lr;
      mag = (mag * 64'd3232284966 + (64'd1 << 37)) >> 38;
      return from_mag(mag, neg);
    endfunction

    function longint unsigned entry_of();
      int nd, kc, k;
      longint unsigned addr, fct;
      nd = dims_in_use();
      kc = (regs.keep_count > 4) ? 4 : regs.keep_count;
      addr = 0;
      fct = 1;
      for (int i = 0; i < kc; i++) begin
        k = regs.keep_order[2*i +: 2];
        if (k < nd) begin
          addr += fct * coord[k];
          fct *= size_of(k);
        end
      end
      return addr;
    endfunction

    function void step_coords();
      int nd;
      nd = dims_in_use();
      for (int d = 0; d < nd; d++) begin
        if (64'(coord[d]) + 1 >= size_of(d)) begin
          coord[d] = '0;
        end else begin
          coord[d]++;
          return;
        end
      end
    endfunction

    function void add_element(longint s, bit ms);
      longint unsigned addr, u;
      longint t;
      addr = entry_of();
      step_coords();
      if (ms) begin
        if (!regs.remove_missing && addr < OutDepth) mark[addr] = 1'b1;
        return;
      end
      if (addr >= OutDepth || mark[addr]) return;
      case (method_t'(regs.method))
        METH_LIN: t = s;
        METH_LOG: begin
          if (s <= 0) begin
            mark[addr] = 1'b1;
            return;
          end
          t = decibels(s);
        end
        METH_SQR: begin
          u = (s < 0) ? -s : s;
          t = (u * u + 64'h8000) >> 16;
        end
        default: begin
          if (s < 0) begin
            mark[addr] = 1'b1;
            return;
          end
          t = root_rounded(unsigned'(s) << 16);
        end
      endcase
      acc[addr] = sat_add(acc[addr], gain_product(t, longint'($signed(regs.scale))));
    endfunction

    function void note(func_t f, logic signed [31:0] smp, bit ms, logic [11:0] idx);
      sum_t r;
      case (f)
        FUNC_ACC: add_element(longint'(smp), ms);
        FUNC_READ: begin
          r.value = acc[idx];
          r.missing = mark[idx];
          expected_sums.push_back(r);
        end
        FUNC_CLEAR: clear();
        default: ;
      endcase
    endfunction

    function void check(longint v, bit m);
      sum_t e;
      if (expected_sums.size() == 0) begin
        $display("%t: unexpected sum transaction, actual %0d/%0b", $realtime, v, m);
        errors++;
        return;
      end
      e = expected_sums.pop_front();
      if (e.value !== v || e.missing !== m) begin
        $display("%t: expected %0d/%0b actual %0d/%0b", $realtime, e.value, e.missing, v, m);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;

  adcs_item_if item_ch();
  adcs_sum_if  sum_ch();

  array_dim_collapse_sum_unit uut (
    .clk(clk), .rst(rst), .item(item_ch), .sum(sum_ch),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  sum_scoreboard sb = new();
  int burst_left = 0;
  bit hold_req = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("array_dim_collapse_sum_unit: mismatch");
    $finish;
  end

  initial begin
    int hold_left, mode_left;
    bit stall_mode, hold_done;
    sum_ch.ready <= 1'b0;
    hold_left = 0;
    mode_left = 150;
    stall_mode = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (sum_ch.valid && sum_ch.ready) sb.check(sum_ch.sum_value, sum_ch.sum_missing);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 6000;
      end
      if (--mode_left == 0) begin
        stall_mode = ~stall_mode;
        mode_left = $urandom_range(50, 250);
      end
      if (hold_left > 0) begin
        hold_left--;
        sum_ch.ready <= 1'b0;
      end else if (stall_mode) begin
        sum_ch.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(func_t f, logic signed [31:0] smp, bit ms, logic [11:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= f;
    item_ch.sample <= smp;
    item_ch.sample_missing <= ms;
    item_ch.read_index <= idx;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note(f, smp, ms, idx);
    burst_left--;
  endtask

  task automatic acc_elem(logic signed [31:0] smp, bit ms = 1'b0);
    send(FUNC_ACC, smp, ms, 12'($urandom));
  endtask

  task automatic read_entry(logic [11:0] idx);
    send(FUNC_READ, $urandom, 1'($urandom), idx);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (4400) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] ds, logic [2:0] nd, logic [7:0] ko, logic [2:0] kc,
                           logic [1:0] meth, bit rm, logic [31:0] sc);
    logic [63:0] vals[7];
    reg_index_t r;
    vals[REG_DIM_SIZES] = ds;
    vals[REG_NUM_DIMS] = 64'(nd);
    vals[REG_KEEP_ORDER] = 64'(ko);
    vals[REG_KEEP_COUNT] = 64'(kc);
    vals[REG_METHOD] = 64'(meth);
    vals[REG_REMOVE_MISSING] = 64'(rm);
    vals[REG_SCALE] = 64'(sc);
    r = r.first();
    for (int i = 0; i < 7; i++) begin
      wr_en <= 1'b1;
      wr_index <= r;
      wr_data <= vals[r];
      @(posedge clk);
      sb.write_reg(r, vals[r]);
      r = r.next();
    end
    wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample(logic [1:0] meth);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) - 1;
      3, 4, 5: return (meth == METH_LOG || meth == METH_ROOT)
                 ? $urandom_range(1, 32'h7FFF_FFFF) : $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic random_phase(bit with_hold);
    logic [63:0] ds;
    logic [2:0] nd, kc;
    logic [1:0] meth;
    logic [31:0] sc;
    int used, cells, n;
    nd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    used = (nd == 0) ? 1 : (nd > 4) ? 4 : nd;
    cells = 1;
    for (int d = 0; d < 4; d++) begin
      if (d < used) begin
        ds[16*d +: 16] = 16'($urandom_range(0, 5));
        cells *= (ds[16*d +: 16] == 0) ? 1 : ds[16*d +: 16];
      end else begin
        ds[16*d +: 16] = 16'($urandom);
      end
    end
    kc = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    meth = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: sc = 32'h7FFF_FFFF;
      1: sc = 32'h8000_0000;
      2: sc = $urandom;
      default: sc = $urandom_range(0, 32'h0003_0000) - 32'h0001_0000;
    endcase
    configure(ds, nd, 8'($urandom), kc, meth, 1'($urandom), sc);
    send(FUNC_CLEAR, $urandom, 1'($urandom), 12'($urandom));
    if (with_hold) hold_req = 1'b1;
    n = (cells * $urandom_range(1, 3) > 90) ? 90 : cells * $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) send(FUNC_NONE, $urandom, 1'($urandom), 12'($urandom));
      if ($urandom_range(0, 7) == 0) read_entry(12'($urandom_range(0, 15)));
      if ($urandom_range(0, 149) == 0) begin
        send(FUNC_CLEAR, $urandom, 1'($urandom), 12'($urandom));
      end
      acc_elem(pick_sample(meth), $urandom_range(0, 11) == 0);
    end
    for (int i = 0; i < 16; i++) read_entry(12'(i));
    read_entry(12'($urandom));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_DIM_SIZES;
    wr_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.func <= FUNC_NONE;
    item_ch.sample <= '0;
    item_ch.sample_missing <= 1'b0;
    item_ch.read_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    acc_elem(32'h7FFF_FFFF);
    acc_elem(32'h8000_0000);
    read_entry(0);
    read_entry(12'hFFF);
    acc_elem(32'h1234_5678, 1'b1);
    send(FUNC_NONE, $urandom, 1'($urandom), 12'($urandom));
    read_entry(0);
    send(FUNC_CLEAR, $urandom, 1'($urandom), 12'($urandom));
    read_entry(0);
    drain();

    configure(64'h0000_0000_0000_0003, 3'd1, 8'd0, 3'd0, METH_SQR, 1'b0, 32'h7FFF_FFFF);
    repeat (4) acc_elem(32'h8000_0000);
    read_entry(0);
    drain();

    configure(64'hFFFF_0000_0000_0006, 3'd1, 8'hFC, 3'd1, METH_LOG, 1'b1, 32'h8000_0000);
    acc_elem(0);
    acc_elem(-5);
    acc_elem(32'h0001_0000);
    acc_elem(1);
    acc_elem(32'h7FFF_FFFF, 1'b1);
    acc_elem(32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) read_entry(12'(i));
    drain();

    configure(64'hFFFF_0000_0000_0040, 3'd3, 8'h00, 3'd3, METH_ROOT, 1'b0, 32'h0001_0000);
    acc_elem(32'h7FFF_FFFF);
    acc_elem(32'h0002_0000);
    acc_elem(-1);
    read_entry(0);
    read_entry(12'd4095);
    drain();

    for (int p = 0; p < 28; p++) random_phase(p == 5);

    if (sb.errors == 0) begin
      $display("array_dim_collapse_sum_unit: match");
    end else begin
      $display("array_dim_collapse_sum_unit: mismatch");
    end
    $finish;
  end
endmodule
